// File: src/vcrd_pkg.sv
// Shared types and codes of the vector clock race detector.
// No dependencies; used by the lane unit and the top level.
`default_nettype none
package vcrd_pkg;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_ACQUIRE = 3'd0;
	localparam cmd_t CMD_RELEASE = 3'd1;
	localparam cmd_t CMD_FORK    = 3'd2;
	localparam cmd_t CMD_JOIN    = 3'd3;
	localparam cmd_t CMD_READ    = 3'd4;
	localparam cmd_t CMD_WRITE   = 3'd5;

	typedef logic lane_op_t;
	localparam lane_op_t OP_MERGE = 1'b0;
	localparam lane_op_t OP_COPY  = 1'b1;

endpackage
`default_nettype wire

// File: src/vcrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vcrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/vcrd_lane_unit.sv
// Shared pointwise unit over one clock row: merge (max) or copy per lane,
// and a flag for any active lane where a exceeds b. Uses vcrd_pkg.
`default_nettype none
module vcrd_lane_unit #(
	parameter int THREADS    = 8,
	parameter int CLOCK_BITS = 32
) (
	input  wire logic [THREADS-1:0][CLOCK_BITS-1:0] a,
	input  wire logic [THREADS-1:0][CLOCK_BITS-1:0] b,
	input  wire logic [THREADS-1:0]                 act,
	input  wire vcrd_pkg::lane_op_t                 op,
	output logic      [THREADS-1:0][CLOCK_BITS-1:0] res,
	output logic                                    gt_any
);

	logic [THREADS-1:0] gt;

	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			gt[i] = a[i] > b[i];
			if (!act[i]) begin
				res[i] = b[i];
			end else if (op == vcrd_pkg::OP_COPY || gt[i]) begin
				res[i] = a[i];
			end else begin
				res[i] = b[i];
			end
		end
		gt_any = |(gt & act);
	end

endmodule
`default_nettype wire

// File: src/vector_clock_race_detector_unit.sv
// Top level of the vector clock race detector: sequencer, clock row stores.
// Depends on vcrd_pkg, vcrd_ram and vcrd_lane_unit.
// Sequence: after the input transfer the rows load in S_LOAD and S_LOADU,
//   pass through the shared lane unit in S_ST1, then S_ST2 and S_ST3 as
//   the event needs, and S_DONE hands the result to the output register.
// One item at a time, set by the single lane unit and the single write port
//   of each row store. Reset: a clearing pass fills all stores, with each
//   thread row set to own entry 1; no input before.
`default_nettype none
module vector_clock_race_detector_unit #(
	parameter int THREADS    = 8,
	parameter int VARS       = 256,
	parameter int LOCKS      = 16,
	parameter int CLOCK_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [3:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [2:0] thread_id,
	input  wire logic [2:0] other_thread,
	input  wire logic [3:0] lock_id,
	input  wire logic [7:0] var_id,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            race
);

	localparam int TW   = $clog2(THREADS);
	localparam int LW   = LOCKS > 1 ? $clog2(LOCKS) : 1;
	localparam int VW   = VARS > 1 ? $clog2(VARS) : 1;
	localparam int NW   = $clog2(THREADS + 1);
	localparam int ML   = VARS > LOCKS ? VARS : LOCKS;
	localparam int CLR_DEPTH = ML > THREADS ? ML : THREADS;
	localparam int CLW  = $clog2(CLR_DEPTH);
	localparam int RW   = THREADS * CLOCK_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_LOADU = 3'd2;
	localparam logic [2:0] S_ST1   = 3'd3;
	localparam logic [2:0] S_ST2   = 3'd4;
	localparam logic [2:0] S_ST3   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	typedef logic [THREADS-1:0][CLOCK_BITS-1:0] row_t;

	logic [2:0]        state_q, state_d;
	logic [3:0]        tc_q;
	logic [NW-1:0]     n;
	logic [THREADS-1:0] act;
	logic              clear_q;
	logic [CLW-1:0]    clr_cnt_q;
	logic              accept;
	logic              ev_ok, ev_ok_q;
	vcrd_pkg::cmd_t    cmd_q;
	logic [TW-1:0]     t_q, u_q;
	logic [LW-1:0]     lk_q;
	logic [VW-1:0]     v_q;
	row_t              thrt_q, thru_q, lck_q, rdr_q, wrr_q;
	logic              race_q, race_set;
	logic              out_valid_q, out_race_q;

	logic              thr_we, lck_we, rd_we, wr_we;
	logic [TW-1:0]     thr_wa, thr_ra;
	logic [LW-1:0]     lck_wa;
	logic [VW-1:0]     var_wa;
	row_t              thr_wd, lck_wd, rd_wd, wr_wd;
	row_t              thr_rd, lck_rd, rd_rd, wr_rd;
	row_t              ident_row;

	row_t              ua, ub, ures;
	vcrd_pkg::lane_op_t uop;
	logic              ugt;

	function automatic row_t tick_lane(input row_t r, input logic [TW-1:0] idx);
		row_t o;
		o = r;
		if (r[idx] != {CLOCK_BITS{1'b1}}) begin
			o[idx] = r[idx] + CLOCK_BITS'(1);
		end
		return o;
	endfunction

	always_comb begin
		if (tc_q == 4'd0) begin
			n = NW'(1);
		end else if (32'(tc_q) > THREADS) begin
			n = NW'(THREADS);
		end else begin
			n = NW'(tc_q);
		end
		for (int i = 0; i < THREADS; i++) begin
			act[i] = i < int'(n);
			ident_row[i] = (i == int'(clr_cnt_q)) ? CLOCK_BITS'(1) : '0;
		end
	end

	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE && !clear_q;

	always_comb begin
		ev_ok = 1'b0;
		if (32'(thread_id) < 32'(n)) begin
			case (command)
				vcrd_pkg::CMD_ACQUIRE, vcrd_pkg::CMD_RELEASE: ev_ok = 32'(lock_id) < LOCKS;
				vcrd_pkg::CMD_FORK, vcrd_pkg::CMD_JOIN: ev_ok = 32'(other_thread) < 32'(n);
				vcrd_pkg::CMD_READ, vcrd_pkg::CMD_WRITE: ev_ok = 32'(var_id) < VARS;
				default: ev_ok = 1'b0;
			endcase
		end
	end

	assign thr_ra = (state_q == S_IDLE) ? TW'(thread_id) : u_q;

	vcrd_ram #(.WIDTH(RW), .DEPTH(THREADS)) u_thr_ram (
		.clk(clk), .we(thr_we), .waddr(thr_wa), .wdata(thr_wd),
		.raddr(thr_ra), .rdata(thr_rd)
	);
	vcrd_ram #(.WIDTH(RW), .DEPTH(LOCKS)) u_lck_ram (
		.clk(clk), .we(lck_we), .waddr(lck_wa), .wdata(lck_wd),
		.raddr(LW'(lock_id)), .rdata(lck_rd)
	);
	vcrd_ram #(.WIDTH(RW), .DEPTH(VARS)) u_rd_ram (
		.clk(clk), .we(rd_we), .waddr(var_wa), .wdata(rd_wd),
		.raddr(VW'(var_id)), .rdata(rd_rd)
	);
	vcrd_ram #(.WIDTH(RW), .DEPTH(VARS)) u_wr_ram (
		.clk(clk), .we(wr_we), .waddr(var_wa), .wdata(wr_wd),
		.raddr(VW'(var_id)), .rdata(wr_rd)
	);

	vcrd_lane_unit #(.THREADS(THREADS), .CLOCK_BITS(CLOCK_BITS)) u_lane (
		.a(ua), .b(ub), .act(act), .op(uop), .res(ures), .gt_any(ugt)
	);

	always_comb begin
		state_d  = state_q;
		race_set = 1'b0;
		thr_we = 1'b0;
		lck_we = 1'b0;
		rd_we  = 1'b0;
		wr_we  = 1'b0;
		thr_wa = t_q;
		lck_wa = lk_q;
		var_wa = v_q;
		thr_wd = ures;
		lck_wd = ures;
		rd_wd  = rdr_q;
		wr_wd  = ures;
		ua  = wrr_q;
		ub  = thrt_q;
		uop = vcrd_pkg::OP_MERGE;
		rd_wd[t_q] = thrt_q[t_q];
		if (clear_q) begin
			thr_we = 32'(clr_cnt_q) < THREADS;
			lck_we = 32'(clr_cnt_q) < LOCKS;
			rd_we  = 32'(clr_cnt_q) < VARS;
			wr_we  = rd_we;
			thr_wa = clr_cnt_q[TW-1:0];
			lck_wa = clr_cnt_q[LW-1:0];
			var_wa = clr_cnt_q[VW-1:0];
			thr_wd = ident_row;
			lck_wd = '0;
			rd_wd  = '0;
			wr_wd  = '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_d = S_LOAD;
				end
				S_LOAD:  state_d = S_LOADU;
				S_LOADU: state_d = S_ST1;
				S_ST1: begin
					state_d = S_DONE;
					if (ev_ok_q) begin
						case (cmd_q)
							vcrd_pkg::CMD_ACQUIRE: begin
								ua = lck_q;
								thr_we = 1'b1;
							end
							vcrd_pkg::CMD_RELEASE: begin
								ua = thrt_q;
								ub = lck_q;
								uop = vcrd_pkg::OP_COPY;
								lck_we = 1'b1;
								state_d = S_ST2;
							end
							vcrd_pkg::CMD_FORK: begin
								ua = thrt_q;
								ub = thru_q;
								thr_wa = u_q;
								thr_we = 1'b1;
								state_d = S_ST2;
							end
							vcrd_pkg::CMD_JOIN: begin
								ua = thru_q;
								thr_we = 1'b1;
								state_d = S_ST2;
							end
							vcrd_pkg::CMD_READ: begin
								if (rdr_q[t_q] != thrt_q[t_q]) begin
									race_set = ugt;
									rd_we = !ugt;
								end
							end
							vcrd_pkg::CMD_WRITE: begin
								if (wrr_q[t_q] != thrt_q[t_q]) begin
									race_set = ugt;
									if (!ugt) state_d = S_ST2;
								end
							end
							default: state_d = S_DONE;
						endcase
					end
				end
				S_ST2: begin
					state_d = S_DONE;
					case (cmd_q)
						vcrd_pkg::CMD_RELEASE, vcrd_pkg::CMD_FORK: begin
							thr_we = 1'b1;
							thr_wd = tick_lane(thrt_q, t_q);
						end
						vcrd_pkg::CMD_JOIN: begin
							thr_we = 1'b1;
							thr_wa = u_q;
							thr_wd = tick_lane(thru_q, u_q);
						end
						vcrd_pkg::CMD_WRITE: begin
							ua = rdr_q;
							race_set = ugt;
							if (!ugt) state_d = S_ST3;
						end
						default: state_d = S_DONE;
					endcase
				end
				S_ST3: begin
					ua = thrt_q;
					ub = wrr_q;
					uop = vcrd_pkg::OP_COPY;
					wr_we = 1'b1;
					state_d = S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tc_q        <= 4'd8;
			clear_q     <= 1'b1;
			clr_cnt_q   <= '0;
			race_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_race_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) tc_q <= cfg_wr_data;
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + CLW'(1);
				if (32'(clr_cnt_q) == CLR_DEPTH - 1) clear_q <= 1'b0;
			end
			if (accept) begin
				race_q <= 1'b0;
			end else if (race_set) begin
				race_q <= 1'b1;
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_race_q  <= race_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			t_q     <= TW'(thread_id);
			u_q     <= TW'(other_thread);
			lk_q    <= LW'(lock_id);
			v_q     <= VW'(var_id);
			ev_ok_q <= ev_ok;
		end
		if (state_q == S_LOAD) begin
			thrt_q <= thr_rd;
			lck_q  <= lck_rd;
			rdr_q  <= rd_rd;
			wrr_q  <= wr_rd;
		end
		if (state_q == S_LOADU) begin
			thru_q <= thr_rd;
		end
	end

	assign out_valid = out_valid_q;
	assign race      = out_race_q;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOAD)
		else $error("transfer not followed by row load");

	a_thr_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(thr_we && !clear_q) |-> (state_q == S_ST1 || state_q == S_ST2))
		else $error("thread row write outside a step");

	a_race_only_access: assert property (@(posedge clk) disable iff (!arst_n)
		(race_q && state_q != S_IDLE) |->
		(cmd_q == vcrd_pkg::CMD_READ || cmd_q == vcrd_pkg::CMD_WRITE))
		else $error("race flagged for a non-access event");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_q) |-> (state_q == S_IDLE && !out_valid_q))
		else $error("clearing pass overlapped work");

endmodule
`default_nettype wire
